// ===== rtl/bagg_pkg.sv =====
// Shared types, register indexes and reset constants of the ballistic aggregation block.
package bagg_pkg;

    localparam int CLUSTER_DEPTH_DEF = 256;

    localparam int POS_W   = 13;
    localparam int COORD_W = 12;
    localparam int RAD_W   = 8;
    localparam int SPEED_W = 6;
    localparam int RSPD_W  = 5;
    localparam int REACH_W = RAD_W + 1;
    localparam int LIM_W   = 2 * REACH_W;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * POS_W + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_RADIUS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_X          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_Y          = 3'd5;

    localparam logic [COORD_W-1:0] FIELD_WIDTH_RST     = 12'd1024;
    localparam logic [COORD_W-1:0] FIELD_HEIGHT_RST    = 12'd768;
    localparam logic [RAD_W-1:0]   CORE_RADIUS_RST     = 8'd45;
    localparam logic [RAD_W-1:0]   PARTICLE_RADIUS_RST = 8'd20;
    localparam logic [COORD_W-1:0] CORE_X_RST          = 12'd512;
    localparam logic [COORD_W-1:0] CORE_Y_RST          = 12'd384;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } point_t;

    typedef struct packed {
        logic   valid;
        point_t part;
        point_t pnt;
    } dist_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bagg_cell.sv =====
// One cell of the point ring: holds a stored point and passes it to its neighbor.
module bagg_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  logic            load_en,
    input  bagg_pkg::point_t shift_in,
    input  bagg_pkg::point_t load_in,
    output bagg_pkg::point_t q
);
    import bagg_pkg::*;

    point_t pt_reg;
    point_t pt_next;

    always_comb begin
        pt_next = pt_reg;
        if (shift_en) begin
            pt_next = shift_in;
        end else if (load_en) begin
            pt_next = load_in;
        end
    end

    always_ff @(posedge aclk) begin
        pt_reg <= pt_next;
    end

    assign q = pt_reg;

endmodule

// ===== rtl/bagg_dist.sv =====
// Two-stage squared-distance compare of the particle against one cluster point.
module bagg_dist (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  bagg_pkg::dist_req_t          req,
    input  logic [bagg_pkg::LIM_W-1:0]   lim,
    output logic                         hit
);
    import bagg_pkg::*;

    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic [SQ_W-1:0]            sq_x_reg;
    logic [SQ_W-1:0]            sq_y_reg;
    logic                       valid_reg;
    logic [SQ_W:0]              dist_sum;

    assign dx = DIFF_W'(req.part.x) - DIFF_W'(req.pnt.x);
    assign dy = DIFF_W'(req.part.y) - DIFF_W'(req.pnt.y);
    assign px = dx * dx;
    assign py = dy * dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= req.valid;
        end
    end

    // squares fit in SQ_W bits: |d| < 2^13
    always_ff @(posedge aclk) begin
        sq_x_reg <= px[SQ_W-1:0];
        sq_y_reg <= py[SQ_W-1:0];
    end

    assign dist_sum = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign hit      = valid_reg && (dist_sum < (SQ_W+1)'(lim));

endmodule

// ===== rtl/ballistic_aggregation_step.sv =====
// Top level of the ballistic aggregation step: control, particle motion and the point ring.
//
// Each item either restarts the run (req_type 0: particle placed at the respawn fields,
// cluster back to the core alone) or advances the particle by one tick (req_type 1).
// Stored cluster points live in a ring of CLUSTER_DEPTH cells that rotates one place per
// cycle past a single pipelined distance unit, so a tick runs through one full
// revolution of the ring, a drain of the compare pipeline, the store of a hit, the
// hand-over of the result to the output register and the idle state that accepts the
// next item. Every item yields exactly one result; the output register lets the
// result wait while the block returns to idle, and a result that waits there longer
// holds the block before its next item. Configuration writes land in registers, the
// capture distance in a register behind them, and are meant for idle periods only.
module ballistic_aggregation_step #(
    parameter int CLUSTER_DEPTH = bagg_pkg::CLUSTER_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config write port
    input  logic                              cfg_wr_en,
    input  logic [bagg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bagg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // respawn_x[11:0], respawn_y[23:12], respawn_vx[28:24], respawn_vy[33:29], zero pad
    input  logic [39:0]                       s_tdata,
    // req_type[0]
    input  logic                              s_tuser,
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pos_x[12:0], pos_y[25:13], stuck[26], stuck_index[34:27], cluster_size[43:35],
    // store_full[44], zero pad
    output logic [47:0]                       m_tdata
);
    import bagg_pkg::*;

    localparam int IW = (CLUSTER_DEPTH > 1) ? $clog2(CLUSTER_DEPTH) : 1;
    localparam int CW = $clog2(CLUSTER_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C    = CW'(CLUSTER_DEPTH);
    localparam logic [IW-1:0] SCAN_LAST  = IW'(CLUSTER_DEPTH - 1);

    // configuration
    logic [COORD_W-1:0] field_width_reg;
    logic [COORD_W-1:0] field_height_reg;
    logic [RAD_W-1:0]   core_radius_reg;
    logic [RAD_W-1:0]   particle_radius_reg;
    logic [COORD_W-1:0] core_x_reg;
    logic [COORD_W-1:0] core_y_reg;
    logic [REACH_W-1:0] reach;
    logic [LIM_W-1:0]   lim_reg;

    // control and particle state
    state_t                     state_reg;
    state_t                     state_next;
    logic [IW-1:0]              scan_reg;
    logic [CW-1:0]              count_reg;
    logic                       hit_reg;
    point_t                     part_reg;
    logic signed [SPEED_W-1:0]  speed_x_reg;
    logic signed [SPEED_W-1:0]  speed_y_reg;
    logic [COORD_W-1:0]         resp_x_reg;
    logic [COORD_W-1:0]         resp_y_reg;
    logic [RSPD_W-1:0]          resp_vx_reg;
    logic [RSPD_W-1:0]          resp_vy_reg;
    logic                       stuck_reg;
    logic [7:0]                 index_reg;
    logic                       full_reg;
    logic                       m_valid_reg;
    logic [47:0]                m_data_reg;

    // fsm outputs
    logic accept;
    logic shift_en;
    logic store_en;
    logic out_load;

    // motion
    logic signed [POS_W:0]      sum_x;
    logic signed [POS_W:0]      sum_y;
    logic signed [POS_W-1:0]    new_x;
    logic signed [POS_W-1:0]    new_y;
    logic signed [SPEED_W-1:0]  new_vx;
    logic signed [SPEED_W-1:0]  new_vy;

    // ring and distance unit
    point_t    ring [CLUSTER_DEPTH];
    point_t    head_pt;
    dist_req_t dreq;
    logic      dist_hit;

    assign reach = REACH_W'(core_radius_reg) + REACH_W'(particle_radius_reg);

    always_ff @(posedge aclk) begin
        lim_reg <= reach * reach;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_width_reg     <= FIELD_WIDTH_RST;
            field_height_reg    <= FIELD_HEIGHT_RST;
            core_radius_reg     <= CORE_RADIUS_RST;
            particle_radius_reg <= PARTICLE_RADIUS_RST;
            core_x_reg          <= CORE_X_RST;
            core_y_reg          <= CORE_Y_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_FIELD_WIDTH:     field_width_reg     <= cfg_wdata[COORD_W-1:0];
                CFG_FIELD_HEIGHT:    field_height_reg    <= cfg_wdata[COORD_W-1:0];
                CFG_CORE_RADIUS:     core_radius_reg     <= cfg_wdata[RAD_W-1:0];
                CFG_PARTICLE_RADIUS: particle_radius_reg <= cfg_wdata[RAD_W-1:0];
                CFG_CORE_X:          core_x_reg          <= cfg_wdata[COORD_W-1:0];
                CFG_CORE_Y:          core_y_reg          <= cfg_wdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick of motion; saturate to 13 bits, bounce speed when outside the field
    assign sum_x = {part_reg.x[POS_W-1], part_reg.x} + (POS_W+1)'(speed_x_reg);
    assign sum_y = {part_reg.y[POS_W-1], part_reg.y} + (POS_W+1)'(speed_y_reg);

    always_comb begin
        new_x = sum_x[POS_W-1:0];
        if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            new_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        new_y = sum_y[POS_W-1:0];
        if (sum_y[POS_W] != sum_y[POS_W-1]) begin
            new_y = sum_y[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        new_vx = speed_x_reg;
        if (new_x[POS_W-1] || (new_x > $signed({1'b0, field_width_reg}))) begin
            new_vx = -speed_x_reg;
        end
        new_vy = speed_y_reg;
        if (new_y[POS_W-1] || (new_y > $signed({1'b0, field_height_reg}))) begin
            new_vy = -speed_y_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_tuser == REQ_START) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_reg == SCAN_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_WRITE;
            ST_WRITE: state_next = ST_DONE;
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready = 1'b0;
        shift_en = 1'b0;
        store_en = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_SCAN:  shift_en = 1'b1;
            ST_DRAIN: ;
            ST_WRITE: store_en = hit_reg && (count_reg < DEPTH_C);
            ST_DONE:  out_load = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg    <= '0;
            count_reg   <= CW'(1);
            hit_reg     <= 1'b0;
            part_reg    <= '0;
            speed_x_reg <= '0;
            speed_y_reg <= '0;
            stuck_reg   <= 1'b0;
            index_reg   <= '0;
            full_reg    <= 1'b0;
        end else begin
            if (accept) begin
                resp_x_reg  <= s_tdata[11:0];
                resp_y_reg  <= s_tdata[23:12];
                resp_vx_reg <= s_tdata[28:24];
                resp_vy_reg <= s_tdata[33:29];
                scan_reg    <= '0;
                hit_reg     <= 1'b0;
                stuck_reg   <= 1'b0;
                index_reg   <= '0;
                full_reg    <= 1'b0;
                if (s_tuser == REQ_START) begin
                    part_reg.x  <= POS_W'(s_tdata[11:0]);
                    part_reg.y  <= POS_W'(s_tdata[23:12]);
                    speed_x_reg <= SPEED_W'(s_tdata[28:24]);
                    speed_y_reg <= SPEED_W'(s_tdata[33:29]);
                    count_reg   <= CW'(1);
                end else begin
                    part_reg.x  <= new_x;
                    part_reg.y  <= new_y;
                    speed_x_reg <= new_vx;
                    speed_y_reg <= new_vy;
                end
            end
            if (shift_en) begin
                scan_reg <= scan_reg + IW'(1);
            end
            if ((state_reg == ST_SCAN || state_reg == ST_DRAIN) && dist_hit) begin
                hit_reg <= 1'b1;
            end
            if (state_reg == ST_WRITE) begin
                stuck_reg <= hit_reg;
                if (hit_reg) begin
                    if (count_reg < DEPTH_C) begin
                        index_reg <= 8'(count_reg);
                        count_reg <= count_reg + CW'(1);
                    end else begin
                        full_reg <= 1'b1;
                    end
                    part_reg.x  <= POS_W'(resp_x_reg);
                    part_reg.y  <= POS_W'(resp_y_reg);
                    speed_x_reg <= SPEED_W'(resp_vx_reg);
                    speed_y_reg <= SPEED_W'(resp_vy_reg);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {3'b000, full_reg, 9'(count_reg), index_reg, stuck_reg,
                           part_reg.y, part_reg.x};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // point ring: cell 0 is the head; after a full revolution it is aligned again
    generate
        for (genvar i = 0; i < CLUSTER_DEPTH; i++) begin : g_cell
            bagg_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .load_en  (store_en && (count_reg[IW-1:0] == IW'(i))),
                .shift_in (ring[(i + 1) % CLUSTER_DEPTH]),
                .load_in  (part_reg),
                .q        (ring[i])
            );
        end
    endgenerate

    // entry zero is the core, taken from the registers
    always_comb begin
        head_pt = ring[0];
        if (scan_reg == '0) begin
            head_pt.x = POS_W'(core_x_reg);
            head_pt.y = POS_W'(core_y_reg);
        end
    end

    assign dreq.valid = shift_en && (CW'(scan_reg) < count_reg);
    assign dreq.part  = part_reg;
    assign dreq.pnt   = head_pt;

    bagg_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .lim     (lim_reg),
        .hit     (dist_hit)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(1)) && (count_reg <= DEPTH_C))
        else $error("cluster count out of range");

    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == REQ_START) |=> (state_reg == ST_DONE && count_reg == CW'(1)))
        else $error("start item did not reset the cluster");

    a_store_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        store_en |=> (count_reg == $past(count_reg) + CW'(1)) && stuck_reg && !full_reg)
        else $error("stored hit did not grow the cluster");

    a_scan_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && scan_reg == SCAN_LAST) |=> state_reg == ST_DRAIN)
        else $error("ring revolution did not end after one pass");

    a_full_no_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && hit_reg && count_reg == DEPTH_C)
        |=> full_reg && stuck_reg && count_reg == DEPTH_C)
        else $error("hit on full store mishandled");
`endif

endmodule
